// ----- design/afgd_pkg.sv -----
// ============================================================================
// afgd_pkg
// Shared types and constants for the audio frame FIFO with grain playback.
// ============================================================================
package afgd_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int MODE_W     = 2;
    localparam int CFG_W      = 14;
    localparam int LVL_OUT_W  = 14;
    localparam int CNT_W      = 48;

    // Grain geometry
    localparam int GRAIN_LEN    = 256;
    localparam int GRAIN_LOG2   = 8;
    localparam int POS_W        = GRAIN_LOG2;
    localparam int REAL_W       = GRAIN_LOG2 + 1;

    // Capacity register reset value
    localparam int CAP_RESET = 3072;

    // Packed port widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = MODE_W;
    localparam int OUT_DATA_W = 256;
    localparam int OUT_USER_W = 3;

    // Item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_START = 2'd3
    } t_mode;

    // One result transaction
    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  left_out;
        logic signed [SAMPLE_W-1:0]  right_out;
        logic                        frame_valid;
        logic                        is_silence;
        logic                        grain_end;
        logic                        write_ok;
        logic [LVL_OUT_W-1:0]        fill_frames;
        logic [LVL_OUT_W-1:0]        peak_fill;
        logic [CNT_W-1:0]            accepted_total;
        logic [CNT_W-1:0]            played_total;
        logic [CNT_W-1:0]            silence_total;
        logic [CNT_W-1:0]            discarded_total;
    } t_result;

endpackage

// ----- design/audio_frame_fifo_grain_drain.sv -----
// ============================================================================
// audio_frame_fifo_grain_drain
// Stereo frame ring FIFO with grain playback, stop/start and running totals.
// ============================================================================
//
//  channel   direction  handshake                 content
//  s_axis    in         i_s_tvalid / o_s_tready   mode, left_in, right_in
//  m_axis    out        o_m_tvalid / i_m_tready   samples, flags, levels, totals
//  cfg       in         i_cfg_valid / o_cfg_ready ring capacity
//
//  One item is taken per clock while intake is not stalled; its result passes
//  the read stage and then the result queue before it is valid on the output:
//  one stage registers the frame memory read, one the result queue.
//  A two-entry result queue lets intake continue while a result waits.
//  Synchronous active-low reset initialises all control state, clears totals; the
//  frame memory is not cleared. Intake stalls only when the queue is full
//  and the read stage still holds a result, or while a config write is offered.
//
module audio_frame_fifo_grain_drain #(
    parameter int MAX_FRAMES = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: left_in[15:0], right_in[31:16]
    input  logic [afgd_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // tuser: mode[1:0]
    input  logic [afgd_pkg::IN_USER_W-1:0]      i_s_tuser,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: left_out[15:0], right_out[31:16], fill_frames[45:32],
    // peak_fill[59:46], accepted_total[107:60], played_total[155:108],
    // silence_total[203:156], discarded_total[251:204], zero pad
    output logic [afgd_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // tuser: frame_valid[0], is_silence[1], write_ok[2]
    output logic [afgd_pkg::OUT_USER_W-1:0]     o_m_tuser,
    output logic                                o_m_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [afgd_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int FW = $clog2(MAX_FRAMES + 1);
    localparam int EW = FW + afgd_pkg::CFG_W;
    localparam int CAP_RST_EFF = (afgd_pkg::CAP_RESET > MAX_FRAMES) ? MAX_FRAMES
                                                                    : afgd_pkg::CAP_RESET;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [afgd_pkg::FRAME_W-1:0] r_mem [MAX_FRAMES];
    logic [afgd_pkg::FRAME_W-1:0] r_rd_data;

    logic [AW-1:0]                r_rp,   n_rp;
    logic [FW-1:0]                r_fill, n_fill;
    logic [FW-1:0]                r_peak, n_peak;
    logic [FW-1:0]                r_cap,  n_cap;
    logic                         r_run,  n_run;
    logic                         r_gip,  n_gip;
    logic [afgd_pkg::POS_W-1:0]   r_pos,  n_pos;
    logic [afgd_pkg::REAL_W-1:0]  r_real, n_real;
    logic [afgd_pkg::CNT_W-1:0]   r_acc,  n_acc;
    logic [afgd_pkg::CNT_W-1:0]   r_play, n_play;
    logic [afgd_pkg::CNT_W-1:0]   r_sil,  n_sil;
    logic [afgd_pkg::CNT_W-1:0]   r_disc, n_disc;

    logic                         r_s1_valid;
    logic                         r_s1_rd;
    afgd_pkg::t_result            r_s1_res;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                         in_acc;
    logic                         cfg_acc;
    logic                         s1_adv;
    afgd_pkg::t_mode              mode;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic                         rd_en;
    logic [FW:0]                  slot_sum;
    logic                         f_valid, f_sil, f_gend, f_wok;
    logic                         gip_v;
    logic [afgd_pkg::POS_W-1:0]   pos_v;
    logic [afgd_pkg::REAL_W-1:0]  real_v;
    logic [afgd_pkg::REAL_W-1:0]  pending;
    logic [FW-1:0]                keep;
    logic [EW-1:0]                cap_round;
    afgd_pkg::t_result            s0_res;
    afgd_pkg::t_result            q_in;
    afgd_pkg::t_result            q_out;
    logic                         q_full;
    logic                         q_valid;

    assign mode        = afgd_pkg::t_mode'(i_s_tuser);
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign s1_adv      = r_s1_valid && !q_full;
    assign o_s_tready  = (!r_s1_valid || !q_full) && !i_cfg_valid;
    assign in_acc      = i_s_tvalid && o_s_tready;

    // Ring slot for a write: read pointer plus fill, wrapped once
    always_comb begin
        slot_sum = {1'b0, FW'(r_rp)} + {1'b0, r_fill};
        if (slot_sum >= {1'b0, r_cap}) begin
            slot_sum = slot_sum - {1'b0, r_cap};
        end
        wr_addr = AW'(slot_sum);
    end

    // Round the written capacity down to whole grains and clamp it
    always_comb begin
        cap_round = EW'(i_cfg_data) & ~EW'(afgd_pkg::GRAIN_LEN - 1);
        n_cap     = r_cap;
        if (cap_round < EW'(2 * afgd_pkg::GRAIN_LEN)) begin
            n_cap = FW'(2 * afgd_pkg::GRAIN_LEN);
        end else if (cap_round > EW'(MAX_FRAMES)) begin
            n_cap = FW'(MAX_FRAMES);
        end else begin
            n_cap = FW'(cap_round);
        end
    end

    // Grain frames latched but not yet played
    always_comb begin
        pending = '0;
        if (r_gip && (afgd_pkg::REAL_W'(r_pos) < r_real)) begin
            pending = r_real - afgd_pkg::REAL_W'(r_pos);
        end
        keep = (FW'(pending) > r_fill) ? r_fill : FW'(pending);
    end

    // Next control state for one item or one config write
    always_comb begin
        n_rp    = r_rp;
        n_fill  = r_fill;
        n_peak  = r_peak;
        n_run   = r_run;
        n_gip   = r_gip;
        n_pos   = r_pos;
        n_real  = r_real;
        n_acc   = r_acc;
        n_play  = r_play;
        n_sil   = r_sil;
        n_disc  = r_disc;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        f_valid = 1'b0;
        f_sil   = 1'b0;
        f_gend  = 1'b0;
        f_wok   = 1'b0;
        gip_v   = r_gip;
        pos_v   = r_pos;
        real_v  = r_real;
        priority if (cfg_acc) begin
            // Empty the ring; the rest of the grain plays as silence
            n_disc = r_disc + afgd_pkg::CNT_W'(r_fill);
            n_fill = '0;
            n_rp   = '0;
            if (r_gip && (r_real > afgd_pkg::REAL_W'(r_pos))) begin
                n_real = afgd_pkg::REAL_W'(r_pos);
            end
        end else if (in_acc) begin
            unique case (mode)
                afgd_pkg::MODE_WRITE: begin
                    if (r_run && (r_fill < r_cap)) begin
                        wr_en  = 1'b1;
                        f_wok  = 1'b1;
                        n_fill = r_fill + FW'(1);
                        n_acc  = r_acc + afgd_pkg::CNT_W'(1);
                        if (n_fill > r_peak) begin
                            n_peak = n_fill;
                        end
                    end
                end
                afgd_pkg::MODE_TICK: begin
                    // Open a grain with up to one grain of real frames
                    if (!r_gip && r_run) begin
                        gip_v  = 1'b1;
                        pos_v  = '0;
                        real_v = (r_fill < FW'(afgd_pkg::GRAIN_LEN))
                                 ? afgd_pkg::REAL_W'(r_fill)
                                 : afgd_pkg::REAL_W'(afgd_pkg::GRAIN_LEN);
                    end
                    if (gip_v) begin
                        f_valid = 1'b1;
                        if ((afgd_pkg::REAL_W'(pos_v) < real_v) && (r_fill != '0)) begin
                            rd_en  = 1'b1;
                            n_rp   = (FW'(r_rp) + FW'(1) >= r_cap) ? '0 : r_rp + AW'(1);
                            n_fill = r_fill - FW'(1);
                            n_play = r_play + afgd_pkg::CNT_W'(1);
                        end else begin
                            f_sil = 1'b1;
                            n_sil = r_sil + afgd_pkg::CNT_W'(1);
                        end
                        if (pos_v == afgd_pkg::POS_W'(afgd_pkg::GRAIN_LEN - 1)) begin
                            f_gend = 1'b1;
                            n_gip  = 1'b0;
                            n_pos  = '0;
                            n_real = '0;
                        end else begin
                            n_gip  = 1'b1;
                            n_pos  = pos_v + afgd_pkg::POS_W'(1);
                            n_real = real_v;
                        end
                    end
                end
                afgd_pkg::MODE_STOP: begin
                    // Drop everything outside the grain in progress
                    n_run  = 1'b0;
                    n_disc = r_disc + afgd_pkg::CNT_W'(r_fill - keep);
                    n_fill = keep;
                end
                afgd_pkg::MODE_START: begin
                    n_run = 1'b1;
                end
                default: begin
                    n_run = r_run;
                end
            endcase
        end else begin
            // Idle cycle: hold all state
            n_run = r_run;
        end
    end

    // Result fields known at intake; samples follow from the memory
    always_comb begin
        s0_res                 = '0;
        s0_res.frame_valid     = f_valid;
        s0_res.is_silence      = f_sil;
        s0_res.grain_end       = f_gend;
        s0_res.write_ok        = f_wok;
        s0_res.fill_frames     = afgd_pkg::LVL_OUT_W'(n_fill);
        s0_res.peak_fill       = afgd_pkg::LVL_OUT_W'(n_peak);
        s0_res.accepted_total  = n_acc;
        s0_res.played_total    = n_play;
        s0_res.silence_total   = n_sil;
        s0_res.discarded_total = n_disc;
    end

    // Control state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_fill <= '0;
            r_peak <= '0;
            r_cap  <= FW'(CAP_RST_EFF);
            r_run  <= 1'b1;
            r_gip  <= 1'b0;
            r_pos  <= '0;
            r_real <= '0;
            r_acc  <= '0;
            r_play <= '0;
            r_sil  <= '0;
            r_disc <= '0;
        end else begin
            r_rp   <= n_rp;
            r_fill <= n_fill;
            r_peak <= n_peak;
            r_run  <= n_run;
            r_gip  <= n_gip;
            r_pos  <= n_pos;
            r_real <= n_real;
            r_acc  <= n_acc;
            r_play <= n_play;
            r_sil  <= n_sil;
            r_disc <= n_disc;
            if (cfg_acc) begin
                r_cap <= n_cap;
            end
        end
    end

    // Frame memory: one access per item, read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_s_tdata[afgd_pkg::FRAME_W-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // Read stage: hold the result until the queue has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res <= s0_res;
            r_s1_rd  <= rd_en;
        end
    end

    // Merge the played samples
    always_comb begin
        q_in = r_s1_res;
        if (r_s1_rd) begin
            q_in.left_out  = r_rd_data[afgd_pkg::SAMPLE_W-1:0];
            q_in.right_out = r_rd_data[afgd_pkg::FRAME_W-1:afgd_pkg::SAMPLE_W];
        end
    end

    afgd_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_adv),
        .i_data  (q_in),
        .i_pop   (i_m_tready),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    // Pack the output stream
    assign o_m_tvalid = q_valid;
    assign o_m_tlast  = q_out.grain_end;
    assign o_m_tuser  = {q_out.write_ok, q_out.is_silence, q_out.frame_valid};
    assign o_m_tdata  = {4'd0,
                         q_out.discarded_total,
                         q_out.silence_total,
                         q_out.played_total,
                         q_out.accepted_total,
                         q_out.peak_fill,
                         q_out.fill_frames,
                         q_out.right_out,
                         q_out.left_out};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_le_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cap)
        else $error("fill level above ring capacity");

    a_pending_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gip && (afgd_pkg::REAL_W'(r_pos) < r_real))
            |-> (FW'(r_real - afgd_pkg::REAL_W'(r_pos)) <= r_fill))
        else $error("latched grain frames exceed fill level");

    a_no_write_stopped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (mode == afgd_pkg::MODE_WRITE) && !r_run) |=> $stable(r_acc))
        else $error("write accepted while stopped");

    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_rd && q_full && !in_acc)
            |=> (r_s1_valid && $stable(r_rd_data)))
        else $error("read stage lost a stalled result");

endmodule

// ----- design/afgd_res_queue.sv -----
// ============================================================================
// afgd_res_queue
// Two-entry result queue between the frame pipeline and the output stream.
// ============================================================================
module afgd_res_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  afgd_pkg::t_result   i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output afgd_pkg::t_result   o_data
);

    afgd_pkg::t_result r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              pop_ok;

    assign pop_ok  = i_pop && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_q[r_rp];

    // Track occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule
